// ----- rtl/pwsf_pkg.sv -----
// Shared types and constants for the packet word scramble framer.
package pwsf_pkg;

  // Width of the packet length field on the input item
  localparam int PLEN_W = 16;

  // Depth of the queue between the front and back parts
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Configuration register indexes
  localparam logic REG_XOR_KEY   = 1'b0;
  localparam logic REG_SHIFT_KEY = 1'b1;

  // Item actions
  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_PAD = 2'd2
  } status_e;

  typedef struct packed {
    logic              action;
    logic              first;
    logic              in_last;
    logic [7:0]        data_byte;
    logic [PLEN_W-1:0] packet_length;
    logic [31:0]       nonce;
    logic [7:0]        tag_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [7:0] tag_out;
    status_e    status;
  } out_item_t;

  // Group of up to eight result bytes produced by one item, oldest in the low byte
  typedef struct packed {
    logic [63:0] data;
    logic [2:0]  cnt_m1;
    logic        last;
    logic [7:0]  tag;
    status_e     status;
  } entry_t;

endpackage

// ----- rtl/packet_word_scramble_framer.sv -----
// Packet word scrambler and descrambler: top level with configuration registers.
// Usage:
//  - Input side is a queue: drive in_item_i and raise push; the item is taken on an
//    edge where full is low. One byte per item, first marks a packet's opening byte
//    and carries its action, length, nonce and tag.
//  - Result side is a queue: while empty is low, out_item_o holds the oldest result
//    byte; raise pop to take it.
//  - Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 xor key,
//    1 shift key) on the edge; write only while no packet is in flight.
//  - Result path: with the back part idle, an item's first result is written into the
//    queue on the accepting edge, then loaded into the back part's output register.
//  - Throughput: one byte per cycle each way. An encode start yields up to eight
//    bytes (nonce plus first word) from one item; a four-entry queue between the
//    classifying front and the byte-serialising back absorbs such bursts.
//  - A stalled receiver fills the queue, then full rises and input holds off; no
//    result is lost or repeated.
//  - Reset clears packet state, keys and queue; the block then ignores bytes
//    until an item with first set.
module packet_word_scramble_framer #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  pwsf_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output pwsf_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);

  logic             accept;
  logic [31:0]      xor_key_q;
  logic [4:0]       shift_key_q;
  logic             q_push, q_rd, q_valid;
  pwsf_pkg::entry_t q_wr_entry, q_rd_entry;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_key_q   <= '0;
      shift_key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwsf_pkg::REG_XOR_KEY:   xor_key_q   <= cfg_data_i;
        pwsf_pkg::REG_SHIFT_KEY: shift_key_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  pwsf_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .xor_key_i   (xor_key_q),
    .shift_key_i (shift_key_q),
    .q_push_o    (q_push),
    .q_entry_o   (q_wr_entry)
  );

  pwsf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_push),
    .wr_data_i (q_wr_entry),
    .rd_en_i   (q_rd),
    .rd_data_o (q_rd_entry),
    .full_o    (full),
    .valid_o   (q_valid)
  );

  pwsf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_data_i   (q_rd_entry),
    .q_valid_i  (q_valid),
    .q_rd_o     (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item_o)
  );

endmodule

// ----- rtl/pwsf_queue.sv -----
// Short entry queue between the front and back parts of the framer.
module pwsf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  pwsf_pkg::entry_t  wr_data_i,
  input  logic              rd_en_i,
  output pwsf_pkg::entry_t  rd_data_o,
  output logic              full_o,
  output logic              valid_o
);

  pwsf_pkg::entry_t mem_q [pwsf_pkg::Q_DEPTH];

  logic [pwsf_pkg::Q_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [pwsf_pkg::Q_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [pwsf_pkg::Q_AW:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = wr_ptr_q + pwsf_pkg::Q_AW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = rd_ptr_q + pwsf_pkg::Q_AW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + (pwsf_pkg::Q_AW + 1)'(1);
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - (pwsf_pkg::Q_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign full_o    = (count_q == (pwsf_pkg::Q_AW + 1)'(pwsf_pkg::Q_DEPTH));
  assign valid_o   = (count_q != '0);

endmodule

// ----- rtl/pwsf_front.sv -----
// Front part: tracks the packet, scrambles or descrambles words, queues result groups.
module pwsf_front #(
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  pwsf_pkg::in_item_t in_item_i,
  input  logic [31:0]        xor_key_i,
  input  logic [4:0]         shift_key_i,
  output logic               q_push_o,
  output pwsf_pkg::entry_t   q_entry_o
);

  localparam int LW = LENGTH_BITS;
  localparam int PW = (LENGTH_BITS < pwsf_pkg::PLEN_W) ? LENGTH_BITS : pwsf_pkg::PLEN_W;

  function automatic logic [31:0] rotl(input logic [31:0] w, input logic [4:0] r);
    logic [63:0] t;
    t = {w, w} << r;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] w, input logic [4:0] r);
    logic [63:0] t;
    t = {w, w} >> r;
    return t[31:0];
  endfunction

  logic          mode_q, mode_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [LW-1:0] end_q, end_d;
  logic [LW-1:0] rlen_q, rlen_d;
  logic [23:0]   gather_q, gather_d;
  logic [31:0]   pkey_q, pkey_d;
  logic [4:0]    rot_q, rot_d;
  logic [1:0]    pad_q, pad_d;
  logic [7:0]    htag_q, htag_d;

  logic [LW-1:0] plen;
  logic [1:0]    k_enc;
  logic [LW+1:0] r_big, r_fit;
  logic          enc_oversize;
  logic [LW-1:0] r_enc;
  logic [31:0]   enc_key;
  logic [4:0]    enc_rot;
  logic [31:0]   enc_w0;
  logic [23:0]   enc_g0;
  logic [LW:0]   pos_inc;
  logic          at_end, pos_ge_end, last_bad, word_done, dec_plen_bad;
  logic [31:0]   w_full, scr_w, scr_key, e_word, d_word;
  logic [4:0]    scr_rot;
  logic          first_w, second_w;
  logic [7:0]    v0;
  logic          pad_fail, len_fail;
  logic [1:0]    pad_new;
  logic [2:0]    keep_s;
  logic [7:0]    tag_new;
  logic [31:0]   d_kept;

  assign plen  = LW'(in_item_i.packet_length[PW-1:0]);
  // Pad count brings payload plus header and tag up to a whole word
  assign k_enc = 2'd2 - plen[1:0];
  assign r_big = (LW+2)'(plen) + (LW+2)'(k_enc) + (LW+2)'(2);
  assign r_fit = r_big + (LW+2)'(4);
  assign enc_oversize = |r_fit[LW+1:LW];
  assign r_enc   = r_big[LW-1:0];
  assign enc_key = 32'(r_enc) ^ xor_key_i ^ in_item_i.nonce;
  assign enc_rot = 5'(r_enc) ^ shift_key_i ^ in_item_i.nonce[4:0];

  // First region word and leftover bytes for an encode start
  always_comb begin
    unique case (k_enc)
      2'd0: begin
        enc_w0 = 32'h0;
        enc_g0 = {in_item_i.data_byte, in_item_i.tag_in, 8'h00};
      end
      2'd1: begin
        enc_w0 = {in_item_i.data_byte, in_item_i.tag_in, 8'h00, 8'h01};
        enc_g0 = 24'h0;
      end
      2'd2: begin
        enc_w0 = {in_item_i.tag_in, 16'h0000, 8'h02};
        enc_g0 = {16'h0000, in_item_i.data_byte};
      end
      default: begin
        enc_w0 = 32'h0000_0003;
        enc_g0 = {8'h00, in_item_i.data_byte, in_item_i.tag_in};
      end
    endcase
  end

  assign pos_inc    = (LW+1)'(pos_q) + (LW+1)'(1);
  assign at_end     = pos_inc >= (LW+1)'(end_q);
  assign pos_ge_end = pos_q >= end_q;
  assign last_bad   = in_item_i.in_last && (pos_inc != (LW+1)'(end_q));
  assign word_done  = (pos_q[1:0] == 2'd3);
  assign dec_plen_bad = (plen == '0) || (plen[1:0] != 2'b00) || (plen < LW'(8));

  assign w_full  = {in_item_i.data_byte, gather_q};
  assign scr_w   = in_item_i.first ? enc_w0 : w_full;
  assign scr_key = in_item_i.first ? enc_key : pkey_q;
  assign scr_rot = in_item_i.first ? enc_rot : rot_q;
  assign e_word  = rotl(scr_w ^ scr_key, scr_rot);
  assign d_word  = rotr(w_full, rot_q) ^ pkey_q;

  // Decoded header: pad count in the first region byte, tag after the pads
  assign first_w  = (pos_q == LW'(7));
  assign second_w = (pos_q == LW'(11));
  assign v0       = d_word[7:0];
  assign pad_fail = first_w && (v0 > 8'd3);
  assign len_fail = first_w && ((LW+1)'(v0) + (LW+1)'(2) > (LW+1)'(rlen_q));
  assign pad_new  = first_w ? v0[1:0] : pad_q;

  always_comb begin
    keep_s  = 3'd0;
    tag_new = htag_q;
    if (first_w) begin
      unique case (pad_new)
        2'd0:    keep_s = 3'd2;
        2'd1:    keep_s = 3'd3;
        default: keep_s = 3'd4;
      endcase
      if (pad_new != 2'd3) begin
        tag_new = d_word[{2'(pad_new + 2'd1), 3'b000} +: 8];
      end
    end else if (second_w && pad_new == 2'd3) begin
      keep_s  = 3'd1;
      tag_new = d_word[7:0];
    end
  end

  assign d_kept = d_word >> {keep_s[1:0], 3'b000};

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    end_d    = end_q;
    rlen_d   = rlen_q;
    gather_d = gather_q;
    pkey_d   = pkey_q;
    rot_d    = rot_q;
    pad_d    = pad_q;
    htag_d   = htag_q;
    q_push_o = 1'b0;
    q_entry_o        = '0;
    q_entry_o.status = pwsf_pkg::ST_OK;

    if (accept_i) begin
      if (in_item_i.first) begin
        // Abandon any packet in flight
        mode_d = pwsf_pkg::ACT_ENCODE;
        pos_d  = '0;
        end_d  = '0;
        rlen_d = '0;
        pad_d  = 2'd0;
        htag_d = 8'h00;
        gather_d = 24'h0;
        if (in_item_i.action == pwsf_pkg::ACT_ENCODE) begin
          if (plen == '0 || enc_oversize ||
              (in_item_i.in_last && plen != LW'(1))) begin
            q_push_o         = 1'b1;
            q_entry_o.last   = 1'b1;
            q_entry_o.status = pwsf_pkg::ST_BAD_LEN;
          end else begin
            rlen_d   = r_enc;
            end_d    = r_enc;
            pad_d    = k_enc;
            htag_d   = in_item_i.tag_in;
            pkey_d   = enc_key;
            rot_d    = enc_rot;
            pos_d    = LW'(k_enc) + LW'(3);
            gather_d = enc_g0;
            q_push_o = 1'b1;
            if (k_enc != 2'd0) begin
              q_entry_o.data   = {e_word, in_item_i.nonce};
              q_entry_o.cnt_m1 = 3'd7;
              q_entry_o.last   = (k_enc == 2'd1) && (r_enc == LW'(4));
            end else begin
              q_entry_o.data   = {32'h0, in_item_i.nonce};
              q_entry_o.cnt_m1 = 3'd3;
            end
          end
        end else begin
          if (dec_plen_bad || in_item_i.in_last) begin
            q_push_o         = 1'b1;
            q_entry_o.last   = 1'b1;
            q_entry_o.status = pwsf_pkg::ST_BAD_LEN;
          end else begin
            mode_d   = pwsf_pkg::ACT_DECODE;
            rlen_d   = plen - LW'(4);
            end_d    = plen;
            pos_d    = LW'(1);
            gather_d = {16'h0000, in_item_i.data_byte};
          end
        end
      end else if (!pos_ge_end) begin
        if (last_bad) begin
          mode_d = pwsf_pkg::ACT_ENCODE;
          pos_d  = '0;
          end_d  = '0;
          rlen_d = '0;
          pad_d  = 2'd0;
          htag_d = 8'h00;
          q_push_o         = 1'b1;
          q_entry_o.last   = 1'b1;
          q_entry_o.status = pwsf_pkg::ST_BAD_LEN;
        end else begin
          pos_d = pos_q + LW'(1);
          unique case (pos_q[1:0])
            2'd0:    gather_d[7:0]   = in_item_i.data_byte;
            2'd1:    gather_d[15:8]  = in_item_i.data_byte;
            2'd2:    gather_d[23:16] = in_item_i.data_byte;
            default: gather_d        = gather_q;
          endcase
          if (word_done) begin
            if (mode_q == pwsf_pkg::ACT_ENCODE) begin
              q_push_o         = 1'b1;
              q_entry_o.data   = {32'h0, e_word};
              q_entry_o.cnt_m1 = 3'd3;
              q_entry_o.last   = at_end;
            end else if (pos_q == LW'(3)) begin
              // Nonce word complete: derive the packet keys
              pkey_d = 32'(rlen_q) ^ xor_key_i ^ w_full;
              rot_d  = 5'(rlen_q) ^ shift_key_i ^ w_full[4:0];
            end else if (pad_fail || len_fail) begin
              mode_d = pwsf_pkg::ACT_ENCODE;
              pos_d  = '0;
              end_d  = '0;
              rlen_d = '0;
              pad_d  = 2'd0;
              htag_d = 8'h00;
              q_push_o         = 1'b1;
              q_entry_o.last   = 1'b1;
              q_entry_o.status = pad_fail ? pwsf_pkg::ST_BAD_PAD : pwsf_pkg::ST_BAD_LEN;
            end else begin
              pad_d  = pad_new;
              htag_d = tag_new;
              q_entry_o.tag  = tag_new;
              q_entry_o.last = at_end;
              if (!keep_s[2]) begin
                q_push_o         = 1'b1;
                q_entry_o.data   = {32'h0, d_kept};
                q_entry_o.cnt_m1 = 3'd3 - keep_s;
              end else if (at_end) begin
                // Empty payload: a lone closing result carries the tag
                q_push_o = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= pwsf_pkg::ACT_ENCODE;
      pos_q    <= '0;
      end_q    <= '0;
      rlen_q   <= '0;
      gather_q <= '0;
      pkey_q   <= '0;
      rot_q    <= '0;
      pad_q    <= '0;
      htag_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      end_q    <= end_d;
      rlen_q   <= rlen_d;
      gather_q <= gather_d;
      pkey_q   <= pkey_d;
      rot_q    <= rot_d;
      pad_q    <= pad_d;
      htag_q   <= htag_d;
    end
  end

endmodule

// ----- rtl/pwsf_back.sv -----
// Back part: takes queued result groups and hands them out one byte per item.
module pwsf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pwsf_pkg::entry_t    q_data_i,
  input  logic                q_valid_i,
  output logic                q_rd_o,
  input  logic                pop,
  output logic                empty,
  output pwsf_pkg::out_item_t out_item_o
);

  pwsf_pkg::entry_t ent_q;
  logic             valid_q, valid_d;
  logic [2:0]       idx_q, idx_d;
  logic             taken, done;

  assign taken  = valid_q && pop;
  assign done   = taken && (idx_q == ent_q.cnt_m1);
  assign q_rd_o = (!valid_q || done) && q_valid_i;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (q_rd_o) begin
      valid_d = 1'b1;
      idx_d   = 3'd0;
    end else if (done) begin
      valid_d = 1'b0;
    end else if (taken) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      ent_q <= q_data_i;
    end
  end

  assign empty               = !valid_q;
  assign out_item_o.out_byte = ent_q.data[{idx_q, 3'b000} +: 8];
  assign out_item_o.out_last = ent_q.last && (idx_q == ent_q.cnt_m1);
  assign out_item_o.tag_out  = ent_q.tag;
  assign out_item_o.status   = ent_q.status;

endmodule
